/* hdl/lfsg_pkg.sv */
// Shared constants, register indexes and saturation helper for the steering gain block.
package lfsg_pkg;

  // Quotient bits resolved by each divider
  localparam int DIV_QB = 32;

  // Q16.16 constants, but W0_NUM_Q is in Q32.32
  localparam logic signed [49:0] KSI_Q      = 50'sd92682;
  localparam logic signed [34:0] HALF_PI_Q  = 35'sd102944;
  localparam logic signed [31:0] ADJ_DIST_Q = 32'sd32768000;  // 500 mm in Q16.16
  localparam logic signed [34:0] W0_NUM_Q   = 35'sd12884901888; // 3.0 in Q32.32

  // Configuration register indexes
  localparam logic [1:0] REG_WHEEL_BASE = 2'd0;
  localparam logic [1:0] REG_SENSOR_AHD = 2'd1;
  localparam logic [1:0] REG_MIN_SPEED  = 2'd2;

  // Reset values
  localparam logic [11:0] WHEEL_BASE_RST = 12'd200;
  localparam logic [11:0] SENSOR_AHD_RST = 12'd100;
  localparam logic [9:0]  MIN_SPEED_RST  = 10'd5;

  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = Q_MAX;
    end else if (x < -64'sd2147483648) begin
      r = Q_MIN;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

/* hdl/lfsg_div.sv */
// Pipelined signed divider, one quotient bit per stage, saturating to 32 bits.
module lfsg_div import lfsg_pkg::*; #(
  parameter int NW = 32,
  parameter int DW = 15,
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic signed [NW-1:0] in_num,
  input  logic signed [DW-1:0] in_den,
  input  logic [SW-1:0]        in_sb,
  output logic                 out_vld,
  output logic signed [31:0]   out_quo,
  output logic [SW-1:0]        out_sb
);

  localparam int NE = (NW > DIV_QB) ? NW : DIV_QB + 1;
  localparam int HW = NE - DIV_QB;
  localparam int MW = (HW > DW) ? HW : DW;

  typedef struct packed {
    logic nneg;
    logic qneg;
    logic nz;
    logic dz;
    logic ovf;
  } dflg_t;

  // Stage 0: magnitudes and signs
  logic [NW-1:0] num_u, an;
  logic [DW-1:0] den_u, ad;
  assign num_u = in_num;
  assign den_u = in_den;
  assign an = num_u[NW-1] ? (~num_u + 1'b1) : num_u;
  assign ad = den_u[DW-1] ? (~den_u + 1'b1) : den_u;

  logic          vld0_r;
  logic [NE-1:0] an0_r;
  logic [DW-1:0] ad0_r;
  dflg_t         flg0_r;
  logic [SW-1:0] sb0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    an0_r       <= NE'(an);
    ad0_r       <= ad;
    flg0_r.nneg <= in_num[NW-1];
    flg0_r.qneg <= in_num[NW-1] ^ in_den[DW-1];
    flg0_r.nz   <= (in_num == '0);
    flg0_r.dz   <= (in_den == '0);
    flg0_r.ovf  <= 1'b0;
    sb0_r       <= in_sb;
  end

  // Stage 1: overflow check and initial remainder
  logic [HW-1:0] hi;
  logic [MW-1:0] hix;
  assign hi  = an0_r[NE-1:DIV_QB];
  assign hix = MW'(hi);

  logic              vld_r [0:DIV_QB];
  logic [DW-1:0]     rem_r [0:DIV_QB];
  logic [DIV_QB-1:0] lo_r  [0:DIV_QB];
  logic [DIV_QB-1:0] q_r   [0:DIV_QB];
  logic [DW-1:0]     ad_r  [0:DIV_QB];
  dflg_t             flg_r [0:DIV_QB];
  logic [SW-1:0]     sb_r  [0:DIV_QB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= vld0_r;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]      <= hix[DW-1:0];
    lo_r[0]       <= an0_r[DIV_QB-1:0];
    q_r[0]        <= '0;
    ad_r[0]       <= ad0_r;
    flg_r[0].nneg <= flg0_r.nneg;
    flg_r[0].qneg <= flg0_r.qneg;
    flg_r[0].nz   <= flg0_r.nz;
    flg_r[0].dz   <= flg0_r.dz;
    flg_r[0].ovf  <= (hix >= MW'(ad0_r));
    sb_r[0]       <= sb0_r;
  end

  // Restoring division, one bit a stage
  for (genvar k = 0; k < DIV_QB; k++) begin : g_bit
    logic [DW:0] trial, dif;
    logic        ge;
    assign trial = {rem_r[k], lo_r[k][DIV_QB-1]};
    assign dif   = trial - {1'b0, ad_r[k]};
    assign ge    = (trial >= {1'b0, ad_r[k]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k+1] <= ge ? dif[DW-1:0] : trial[DW-1:0];
      lo_r[k+1]  <= {lo_r[k][DIV_QB-2:0], 1'b0};
      q_r[k+1]   <= {q_r[k][DIV_QB-2:0], ge};
      ad_r[k+1]  <= ad_r[k];
      flg_r[k+1] <= flg_r[k];
      sb_r[k+1]  <= sb_r[k];
    end
  end

  // Sign, zero divisor and saturation
  logic [DIV_QB-1:0] qm, qneg_v;
  logic signed [31:0] quo_nxt;
  dflg_t fl;
  assign qm     = q_r[DIV_QB];
  assign qneg_v = ~qm + 1'b1;
  assign fl     = flg_r[DIV_QB];

  always_comb begin
    if (fl.dz) begin
      quo_nxt = fl.nz ? '0 : (fl.nneg ? Q_MIN : Q_MAX);
    end else if (fl.ovf) begin
      quo_nxt = fl.qneg ? Q_MIN : Q_MAX;
    end else if (fl.qneg) begin
      quo_nxt = (qm > 32'h80000000) ? Q_MIN : qneg_v;
    end else begin
      quo_nxt = qm[31] ? Q_MAX : qm;
    end
  end

  logic               out_vld_r;
  logic signed [31:0] out_quo_r;
  logic [SW-1:0]      out_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_r[DIV_QB];
    end
  end

  always_ff @(posedge clk) begin
    out_quo_r <= quo_nxt;
    out_sb_r  <= sb_r[DIV_QB];
  end

  assign out_vld = out_vld_r;
  assign out_quo = out_quo_r;
  assign out_sb  = out_sb_r;

endmodule

/* hdl/line_follow_steering_gain.sv */
// Top level: pole-placement steering angle for a line-following car.
//
// Usage:
//   Input channel: drive in_* fields and pulse start; a beat is taken at
//   every edge with start high and busy low. busy is always low, so a new
//   beat can be taken every cycle.
//   Result channel: out_strobe is high for one cycle with out_steer_angle;
//   the receiver cannot stall, so no backpressure exists.
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
//   cfg_ready is always high. Write only while no beat is in flight.
//   Throughput: one beat per cycle. Latency is set by five chained
//   bit-per-stage dividers of 35 stages each (a sixth runs beside one of
//   them) plus the input, multiply, scale, sum and output stages.
//   Reset: empties the pipeline and loads wheel base 200, sensor ahead
//   100 and minimum speed 5.
//   Below minimum speed, or with zero lever length, the result is zero.
module line_follow_steering_gain import lfsg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [14:0] in_speed_mm_s,
  input  logic signed [11:0] in_baseline_mm,
  input  logic signed [11:0] in_line_offset_mm,
  input  logic signed [13:0] in_line_angle,
  output logic               out_strobe,
  output logic signed [13:0] out_steer_angle,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [11:0]        cfg_data
);

  typedef struct packed {
    logic               gate;
    logic signed [14:0] v;
    logic signed [12:0] diff;
    logic signed [13:0] ang;
  } item_t;

  typedef struct packed {
    logic               gate;
    logic signed [14:0] v;
    logic signed [13:0] ang;
    logic signed [32:0] sre;
  } itm4_t;

  typedef struct packed {
    logic               gate;
    logic signed [13:0] ang;
    logic signed [31:0] uloc;
  } itm5_t;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration registers
  logic [11:0] wheel_base_r, sensor_ahd_r;
  logic [9:0]  speed_floor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_base_r  <= WHEEL_BASE_RST;
      sensor_ahd_r  <= SENSOR_AHD_RST;
      speed_floor_r <= MIN_SPEED_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WHEEL_BASE: wheel_base_r  <= cfg_data;
        REG_SENSOR_AHD: sensor_ahd_r  <= cfg_data;
        REG_MIN_SPEED:  speed_floor_r <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  logic [12:0] len;
  assign len = {1'b0, wheel_base_r} + {1'b0, sensor_ahd_r};

  // S0: input register
  logic               s0_vld_r;
  logic signed [14:0] s0_v_r;
  logic signed [11:0] s0_base_r, s0_pos_r;
  logic signed [13:0] s0_ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_v_r    <= in_speed_mm_s;
    s0_base_r <= in_baseline_mm;
    s0_pos_r  <= in_line_offset_mm;
    s0_ang_r  <= in_line_angle;
  end

  // Adjust distance, speed gate
  logic [14:0]        av;
  logic signed [31:0] adj_dist;
  item_t              it1;
  assign av       = s0_v_r[14] ? (~s0_v_r + 1'b1) : s0_v_r;
  assign adj_dist = ADJ_DIST_Q + 32'(s0_v_r) * 32'sd32768;
  assign it1.gate = (av >= {5'b0, speed_floor_r}) && (len != '0);
  assign it1.v    = s0_v_r;
  assign it1.diff = {s0_base_r[11], s0_base_r} - {s0_pos_r[11], s0_pos_r};
  assign it1.ang  = s0_ang_r;

  // D1: adjust time
  logic               d1_vld;
  logic signed [31:0] d1_q;
  logic [$bits(item_t)-1:0] d1_sb;

  lfsg_div #(.NW(32), .DW(15), .SW($bits(item_t))) u_div_ta (
    .clk(clk), .rst_n(rst_n), .in_vld(s0_vld_r), .in_num(adj_dist), .in_den(s0_v_r),
    .in_sb(it1), .out_vld(d1_vld), .out_quo(d1_q), .out_sb(d1_sb)
  );

  // A: ta * ksi
  logic               a_vld_r;
  logic signed [49:0] a_p_r;
  item_t              a_it_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    a_p_r  <= 50'(d1_q) * KSI_Q;
    a_it_r <= d1_sb;
  end

  // B: scale to Q16.16, toward zero
  logic signed [49:0] a_sh;
  assign a_sh = a_p_r[49] ? ((a_p_r + 50'sd65535) >>> 16) : (a_p_r >>> 16);

  logic               b_vld_r;
  logic signed [31:0] b_kt_r;
  item_t              b_it_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    b_kt_r <= sat32(64'(a_sh));
    b_it_r <= a_it_r;
  end

  // D2: w0 = 3 / (ksi * ta)
  logic               d2_vld;
  logic signed [31:0] d2_q;
  logic [$bits(item_t)-1:0] d2_sb;

  lfsg_div #(.NW(35), .DW(32), .SW($bits(item_t))) u_div_w0 (
    .clk(clk), .rst_n(rst_n), .in_vld(b_vld_r), .in_num(W0_NUM_Q), .in_den(b_kt_r),
    .in_sb(b_it_r), .out_vld(d2_vld), .out_quo(d2_q), .out_sb(d2_sb)
  );

  // C: w0^2 and w0 * ksi
  logic               c_vld_r;
  logic signed [63:0] c_sq_r;
  logic signed [49:0] c_ks_r;
  item_t              c_it_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    c_sq_r <= 64'(d2_q) * 64'(d2_q);
    c_ks_r <= 50'(d2_q) * KSI_Q;
    c_it_r <= d2_sb;
  end

  // D: scale, pole real part
  logic signed [49:0] c_ks_sh;
  logic signed [31:0] c_ks_sat;
  assign c_ks_sh  = c_ks_r[49] ? ((c_ks_r + 50'sd65535) >>> 16) : (c_ks_r >>> 16);
  assign c_ks_sat = sat32(64'(c_ks_sh));

  logic               dd_vld_r;
  logic signed [31:0] dd_w0sq_r;
  logic signed [32:0] dd_sre_r;
  item_t              dd_it_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dd_vld_r <= 1'b0;
    end else begin
      dd_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    dd_w0sq_r <= sat32(c_sq_r >>> 16);
    dd_sre_r  <= -(33'(c_ks_sat));
    dd_it_r   <= c_it_r;
  end

  // E: L * w0^2 and v^2
  logic               e_vld_r;
  logic signed [45:0] e_lw_r;
  logic signed [30:0] e_vv_r;
  logic signed [32:0] e_sre_r;
  item_t              e_it_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else begin
      e_vld_r <= dd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    e_lw_r  <= 46'($signed({1'b0, len})) * 46'(dd_w0sq_r);
    e_vv_r  <= 31'(dd_it_r.v) * 31'(dd_it_r.v);
    e_sre_r <= dd_sre_r;
    e_it_r  <= dd_it_r;
  end

  // F: position numerator
  logic               f_vld_r;
  logic signed [59:0] f_num3_r;
  logic signed [45:0] f_lw_r;
  logic signed [30:0] f_vv_r;
  itm4_t              f_it4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= e_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    f_num3_r     <= -(60'(e_lw_r) * 60'(e_it_r.diff));
    f_lw_r       <= e_lw_r;
    f_vv_r       <= e_vv_r;
    f_it4_r.gate <= e_it_r.gate;
    f_it4_r.v    <= e_it_r.v;
    f_it4_r.ang  <= e_it_r.ang;
    f_it4_r.sre  <= e_sre_r;
  end

  // D3: position term, D4: L * w0^2 / v, side by side
  logic               d3_vld, d4_vld;
  logic signed [31:0] d3_q, d4_q;
  logic               d3_sb;
  logic [$bits(itm4_t)-1:0] d4_sb;

  lfsg_div #(.NW(60), .DW(31), .SW(1)) u_div_loc (
    .clk(clk), .rst_n(rst_n), .in_vld(f_vld_r), .in_num(f_num3_r), .in_den(f_vv_r),
    .in_sb(f_it4_r.gate), .out_vld(d3_vld), .out_quo(d3_q), .out_sb(d3_sb)
  );

  lfsg_div #(.NW(46), .DW(15), .SW($bits(itm4_t))) u_div_lwv (
    .clk(clk), .rst_n(rst_n), .in_vld(f_vld_r), .in_num(f_lw_r), .in_den(f_it4_r.v),
    .in_sb(f_it4_r), .out_vld(d4_vld), .out_quo(d4_q), .out_sb(d4_sb)
  );

  itm4_t d4_it;
  assign d4_it = d4_sb;

  // G: orientation term
  logic               g_vld_r;
  logic signed [31:0] g_term_r;
  itm4_t              g_it_r;
  logic signed [31:0] g_uloc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
    end else begin
      g_vld_r <= d3_vld & d4_vld;
    end
  end

  always_ff @(posedge clk) begin
    g_term_r    <= sat32((64'(d4_it.sre) * 64'sd2) + 64'(d4_q));
    g_it_r.gate <= d4_it.gate & d3_sb;
    g_it_r.v    <= d4_it.v;
    g_it_r.ang  <= d4_it.ang;
    g_it_r.sre  <= d4_it.sre;
    g_uloc_r    <= d3_q;
  end

  // H: L * term
  logic               h_vld_r;
  logic signed [45:0] h_num5_r;
  itm5_t              h_it_r;
  logic signed [14:0] h_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_vld_r <= 1'b0;
    end else begin
      h_vld_r <= g_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    h_num5_r    <= 46'($signed({1'b0, len})) * 46'(g_term_r);
    h_it_r.gate <= g_it_r.gate;
    h_it_r.ang  <= g_it_r.ang;
    h_it_r.uloc <= g_uloc_r;
    h_v_r       <= g_it_r.v;
  end

  // D5: orientation gain
  logic               d5_vld;
  logic signed [31:0] d5_q;
  logic [$bits(itm5_t)-1:0] d5_sb;

  lfsg_div #(.NW(46), .DW(15), .SW($bits(itm5_t))) u_div_ko (
    .clk(clk), .rst_n(rst_n), .in_vld(h_vld_r), .in_num(h_num5_r), .in_den(h_v_r),
    .in_sb(h_it_r), .out_vld(d5_vld), .out_quo(d5_q), .out_sb(d5_sb)
  );

  itm5_t d5_it;
  assign d5_it = d5_sb;

  // I: Ko * angle
  logic               i_vld_r;
  logic signed [45:0] i_pk_r;
  logic signed [31:0] i_uloc_r;
  logic               i_gate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_vld_r <= 1'b0;
    end else begin
      i_vld_r <= d5_vld;
    end
  end

  always_ff @(posedge clk) begin
    i_pk_r   <= 46'(d5_q) * 46'(d5_it.ang);
    i_uloc_r <= d5_it.uloc;
    i_gate_r <= d5_it.gate;
  end

  // J: sum and clamp to +-pi/2
  logic signed [45:0] i_sh;
  logic signed [34:0] phi_raw;
  assign i_sh    = i_pk_r[45] ? ((i_pk_r + 46'sd4095) >>> 12) : (i_pk_r >>> 12);
  assign phi_raw = 35'(i_uloc_r) + 35'(i_sh);

  logic               j_vld_r;
  logic signed [17:0] j_phi_r;
  logic               j_gate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_vld_r <= 1'b0;
    end else begin
      j_vld_r <= i_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (phi_raw > HALF_PI_Q) begin
      j_phi_r <= 18'(HALF_PI_Q);
    end else if (phi_raw < -HALF_PI_Q) begin
      j_phi_r <= 18'(-HALF_PI_Q);
    end else begin
      j_phi_r <= phi_raw[17:0];
    end
    j_gate_r <= i_gate_r;
  end

  // K: phi * wheel base
  logic               k_vld_r;
  logic signed [30:0] k_num6_r;
  logic signed [17:0] k_den6_r;
  logic               k_gate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_vld_r <= 1'b0;
    end else begin
      k_vld_r <= j_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    k_num6_r <= 31'(j_phi_r) * 31'($signed({1'b0, wheel_base_r}));
    k_den6_r <= $signed({1'b0, len, 4'b0});
    k_gate_r <= j_gate_r;
  end

  // D6: scale to front wheel
  logic               d6_vld;
  logic signed [31:0] d6_q;
  logic               d6_gate;

  lfsg_div #(.NW(31), .DW(18), .SW(1)) u_div_out (
    .clk(clk), .rst_n(rst_n), .in_vld(k_vld_r), .in_num(k_num6_r), .in_den(k_den6_r),
    .in_sb(k_gate_r), .out_vld(d6_vld), .out_quo(d6_q), .out_sb(d6_gate)
  );

  // Output register
  logic               out_strobe_r;
  logic signed [13:0] out_steer_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= d6_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_steer_r <= d6_gate ? d6_q[13:0] : '0;
  end

  assign out_strobe      = out_strobe_r;
  assign out_steer_angle = out_steer_r;

endmodule
